@@ src/ffha_pkg.sv @@
package ffha_pkg;

  // Default heap geometry
  localparam int unsigned HeapUnitsDef   = 1024;
  localparam int unsigned UnitBytesDef   = 64;
  localparam int unsigned HeaderUnitsDef = 1;

  // Fixed field widths
  localparam int unsigned SizeW   = 17;
  localparam int unsigned AddrW   = 10;
  localparam int unsigned StatusW = 2;
  // Rounded byte count: size plus up to one unit minus one byte
  localparam int unsigned NumW    = 18;
  // Units needed: quotient plus header
  localparam int unsigned NeedW   = 20;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_FREE = 2'd1,
    KIND_USED = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK   = 2'd0,
    ST_NULL = 2'd1,
    ST_FAIL = 2'd2
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_e;

  typedef struct packed {
    logic             command;
    logic [SizeW-1:0] size_bytes;
    logic [AddrW-1:0] address_unit;
  } ffha_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [AddrW-1:0]   payload_unit;
  } ffha_rsp_t;

endpackage

@@ src/ffha_div.sv @@
module ffha_div import ffha_pkg::*; #(
  parameter int unsigned Divisor = UnitBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] dividend_i,
  output logic            done_o,
  output logic [NumW-1:0] quotient_o
);

  // Reciprocal of the divisor, scaled so that the truncated product is exact
  // for every NumW-bit dividend
  localparam int unsigned     Shift  = NumW + $clog2(Divisor);
  localparam longint unsigned Recip  = ((64'd1 << Shift) + Divisor - 1) / Divisor;
  localparam int unsigned     RecipW = NumW + 2;
  localparam int unsigned     ProdW  = NumW + RecipW;

  logic [ProdW-1:0] prod;
  logic [NumW-1:0]  quo_q, quo_d;
  logic             done_q, done_d;

  // Multiply by the reciprocal and keep the high part
  assign prod   = ProdW'(dividend_i) * ProdW'(Recip);
  assign quo_d  = NumW'(prod >> Shift);
  assign done_d = start_i;

  // Flag the quotient in the cycle after start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  // Capture the quotient on start and hold it
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ src/ffha_table.sv @@
module ffha_table import ffha_pkg::*; #(
  parameter int unsigned Depth = HeapUnitsDef,
  parameter int unsigned LenW  = $clog2(HeapUnitsDef + 1)
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  kind_e                    wr_kind_i,
  input  logic [LenW-1:0]          wr_len_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output kind_e                    rd_kind_o,
  output logic [LenW-1:0]          rd_len_o
);

  kind_e           kind_mem [Depth];
  logic [LenW-1:0] len_mem  [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      kind_mem[wr_addr_i] <= wr_kind_i;
      len_mem[wr_addr_i]  <= wr_len_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_kind_o <= kind_mem[rd_addr_i];
      rd_len_o  <= len_mem[rd_addr_i];
    end
  end

endmodule

@@ src/first_fit_heap_allocator_core.sv @@
// First-fit heap allocator over HeapUnits units of UnitBytes bytes, each
// block led by a HeaderUnits-unit header. The block table sits in one
// synchronous memory indexed by block start. An allocate, or a free of an
// allocated block, walks it in address order, reading each block visited
// and then checking it. After reset a clearing pass over every entry
// initializes the table; the input is stalled until it ends. An allocate
// takes the beat, turns the byte count into units in the divider, visits
// blocks up to the first fit, then writes back and loads the result. A free
// checks the block, visits each block below it to find its lower neighbor,
// then reads the upper neighbor, writes back the merge and loads the
// result. A null or out-of-range free goes straight to the result. Every
// command gives exactly one result beat.
module first_fit_heap_allocator_core import ffha_pkg::*; #(
  parameter int unsigned HeapUnits   = HeapUnitsDef,
  parameter int unsigned UnitBytes   = UnitBytesDef,
  parameter int unsigned HeaderUnits = HeaderUnitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ffha_req_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ffha_rsp_t out_data_o
);

  localparam int unsigned LenW = $clog2(HeapUnits + 1);
  localparam int unsigned IdxW = $clog2(HeapUnits);

  typedef enum logic [13:0] {
    S_CLR  = 14'b00000000000001,
    S_IDLE = 14'b00000000000010,
    S_DIV  = 14'b00000000000100,
    S_ARD  = 14'b00000000001000,
    S_ACK  = 14'b00000000010000,
    S_AWR  = 14'b00000000100000,
    S_FCK  = 14'b00000001000000,
    S_FWRD = 14'b00000010000000,
    S_FWCK = 14'b00000100000000,
    S_FNRD = 14'b00001000000000,
    S_FNCK = 14'b00010000000000,
    S_FW2  = 14'b00100000000000,
    S_FW3  = 14'b01000000000000,
    S_RESP = 14'b10000000000000
  } state_e;

  state_e           state_q, state_d;
  logic [LenW-1:0]  pos_q, pos_d;
  logic [NeedW-1:0] need_q, need_d;
  logic [LenW-1:0]  start_q, start_d;
  logic [LenW-1:0]  slen_q, slen_d;
  logic [LenW-1:0]  prev_q, prev_d;
  logic [LenW-1:0]  plen_q, plen_d;
  logic             pfree_q, pfree_d;
  logic             nfree_q, nfree_d;
  logic [LenW-1:0]  nlen_q, nlen_d;
  status_e          res_st_q, res_st_d;
  logic [AddrW-1:0] res_unit_q, res_unit_d;
  logic             out_valid_q, out_valid_d;
  ffha_rsp_t        out_data_q, out_data_d;

  // Memory and divider hookups
  logic            wr_en, rd_en;
  logic [IdxW-1:0] wr_addr, rd_addr;
  kind_e           wr_kind, rd_kind;
  logic [LenW-1:0] wr_len, rd_len;
  logic            div_start, div_done;
  logic [NumW-1:0] div_num, div_quo;

  logic [AddrW-1:0] addr_start;
  logic [LenW-1:0]  nxt;
  logic [LenW-1:0]  merged;
  logic             in_fire;

  assign in_fire    = in_valid_i && (state_q == S_IDLE);
  assign addr_start = in_data_i.address_unit - AddrW'(HeaderUnits);
  assign div_num    = NumW'(in_data_i.size_bytes) + NumW'(UnitBytes - 1);
  assign nxt        = start_q + slen_q;
  assign merged     = slen_q + (nfree_q ? nlen_q : '0);

  ffha_div #(
    .Divisor(UnitBytes)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  ffha_table #(
    .Depth(HeapUnits),
    .LenW (LenW)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_kind_i(wr_kind),
    .wr_len_i (wr_len),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_kind_o(rd_kind),
    .rd_len_o (rd_len)
  );

  // Sequencer: one command at a time; the memory is never read and written
  // at the same entry in one cycle, so no forwarding is needed
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    need_d      = need_q;
    start_d     = start_q;
    slen_d      = slen_q;
    prev_d      = prev_q;
    plen_d      = plen_q;
    pfree_d     = pfree_q;
    nfree_d     = nfree_q;
    nlen_d      = nlen_q;
    res_st_d    = res_st_q;
    res_unit_d  = res_unit_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    wr_en       = 1'b0;
    wr_addr     = pos_q[IdxW-1:0];
    wr_kind     = KIND_NONE;
    wr_len      = '0;
    rd_en       = 1'b0;
    rd_addr     = pos_q[IdxW-1:0];
    div_start   = 1'b0;

    case (state_q)
      // Sweep the table once after reset
      S_CLR: begin
        wr_en = 1'b1;
        if (pos_q == '0) begin
          wr_kind = KIND_FREE;
          wr_len  = LenW'(HeapUnits);
        end
        if (pos_q == LenW'(HeapUnits - 1)) begin
          pos_d   = '0;
          state_d = S_IDLE;
        end else begin
          pos_d = pos_q + LenW'(1);
        end
      end

      // Take a command beat and screen frees
      S_IDLE: begin
        res_unit_d = '0;
        if (in_fire) begin
          if (in_data_i.command == CMD_ALLOC) begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end else if (in_data_i.address_unit == '0) begin
            res_st_d = ST_NULL;
            state_d  = S_RESP;
          end else if (32'(in_data_i.address_unit) < HeaderUnits ||
                       32'(addr_start) >= HeapUnits) begin
            res_st_d = ST_FAIL;
            state_d  = S_RESP;
          end else begin
            start_d = LenW'(addr_start);
            rd_en   = 1'b1;
            rd_addr = IdxW'(addr_start);
            state_d = S_FCK;
          end
        end
      end

      // Units needed: at least one payload unit plus the header
      S_DIV: begin
        if (div_done) begin
          need_d  = ((div_quo == '0) ? NeedW'(1) : NeedW'(div_quo)) +
                    NeedW'(HeaderUnits);
          pos_d   = '0;
          state_d = S_ARD;
        end
      end

      S_ARD: begin
        if (32'(pos_q) >= HeapUnits) begin
          res_st_d = ST_FAIL;
          state_d  = S_RESP;
        end else begin
          rd_en   = 1'b1;
          state_d = S_ACK;
        end
      end

      // Take the first free block that fits; split off the remainder
      S_ACK: begin
        if (rd_kind == KIND_FREE && 32'(rd_len) >= 32'(need_q)) begin
          slen_d = LenW'(need_q);
          if (32'(rd_len) > 32'(need_q)) begin
            wr_en   = 1'b1;
            wr_addr = IdxW'(pos_q + LenW'(need_q));
            wr_kind = KIND_FREE;
            wr_len  = rd_len - LenW'(need_q);
          end
          state_d = S_AWR;
        end else if (rd_len == '0) begin
          res_st_d = ST_FAIL;
          state_d  = S_RESP;
        end else begin
          pos_d   = pos_q + rd_len;
          state_d = S_ARD;
        end
      end

      S_AWR: begin
        wr_en      = 1'b1;
        wr_kind    = KIND_USED;
        wr_len     = slen_q;
        res_st_d   = ST_OK;
        res_unit_d = AddrW'(32'(pos_q) + HeaderUnits);
        state_d    = S_RESP;
      end

      // Check that the address starts an allocated block
      S_FCK: begin
        if (rd_kind != KIND_USED) begin
          res_st_d = ST_FAIL;
          state_d  = S_RESP;
        end else begin
          slen_d  = rd_len;
          pos_d   = '0;
          pfree_d = 1'b0;
          state_d = S_FWRD;
        end
      end

      // Walk up to the freed block to find its lower neighbor
      S_FWRD: begin
        if (pos_q < start_q) begin
          rd_en   = 1'b1;
          state_d = S_FWCK;
        end else begin
          state_d = S_FNRD;
        end
      end

      S_FWCK: begin
        if (rd_len == '0) begin
          state_d = S_FNRD;
        end else begin
          prev_d  = pos_q;
          pfree_d = (rd_kind == KIND_FREE);
          plen_d  = rd_len;
          pos_d   = pos_q + rd_len;
          state_d = S_FWRD;
        end
      end

      // Read the upper neighbor
      S_FNRD: begin
        nfree_d = 1'b0;
        if (32'(nxt) < HeapUnits) begin
          rd_en   = 1'b1;
          rd_addr = nxt[IdxW-1:0];
          state_d = S_FNCK;
        end else begin
          state_d = S_FW2;
        end
      end

      // Absorb a free upper neighbor
      S_FNCK: begin
        if (rd_kind == KIND_FREE) begin
          nfree_d = 1'b1;
          nlen_d  = rd_len;
          wr_en   = 1'b1;
          wr_addr = nxt[IdxW-1:0];
          wr_kind = KIND_NONE;
          wr_len  = '0;
        end
        state_d = S_FW2;
      end

      // Write the freed block, or drop it into a free lower neighbor
      S_FW2: begin
        wr_en   = 1'b1;
        wr_addr = start_q[IdxW-1:0];
        slen_d  = merged;
        if (pfree_q) begin
          wr_kind = KIND_NONE;
          wr_len  = '0;
          state_d = S_FW3;
        end else begin
          wr_kind  = KIND_FREE;
          wr_len   = merged;
          res_st_d = ST_OK;
          state_d  = S_RESP;
        end
      end

      S_FW3: begin
        wr_en    = 1'b1;
        wr_addr  = prev_q[IdxW-1:0];
        wr_kind  = KIND_FREE;
        wr_len   = plen_q + slen_q;
        res_st_d = ST_OK;
        state_d  = S_RESP;
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d             = 1'b1;
          out_data_d.status       = res_st_q;
          out_data_d.payload_unit = res_unit_q;
          state_d                 = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q     <= need_d;
    start_q    <= start_d;
    slen_q     <= slen_d;
    prev_q     <= prev_d;
    plen_q     <= plen_d;
    pfree_q    <= pfree_d;
    nfree_q    <= nfree_d;
    nlen_q     <= nlen_d;
    res_st_q   <= res_st_d;
    res_unit_q <= res_unit_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
